@@ rtl/clps_pkg.sv @@
// Package for the character display sequencer: shared types, constants and command tables.
package clps_pkg;

    localparam int unsigned INIT_STEPS = 8;

    localparam logic [7:0] CLEAR_CMD   = 8'h01;
    localparam logic [7:0] CLEAR_DELAY = 8'd10;

    localparam logic [7:0] PULSE_RESET = 8'd10;
    localparam logic [7:0] CLEAR_RESET = 8'd99;
    localparam logic [7:0] POWER_RESET = 8'd17;

    // Configuration register indexes
    localparam logic [1:0] CFG_PULSE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_CLEAR_CODE  = 2'd1;
    localparam logic [1:0] CFG_POWER_WAIT  = 2'd2;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0] data_bus;
        logic       reg_select;
        logic       read_write;
        logic       enable_line;
        logic       busy_res;
        logic       dropped;
    } result_t;

    // Init command for a step; steps past the table replay the last entry.
    function automatic logic [7:0] init_cmd(input logic [3:0] idx);
        logic [7:0] code;
        case (idx)
            4'd0:    code = 8'h30;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h30;
            4'd3:    code = 8'h38;
            4'd4:    code = 8'h08;
            4'd5:    code = 8'h01;
            4'd6:    code = 8'h06;
            default: code = 8'h0F;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] init_delay(input logic [3:0] idx);
        logic [7:0] d;
        case (idx)
            4'd0:    d = 8'd5;
            4'd1:    d = 8'd2;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/clps_if.sv @@
// Valid/ready channel interfaces for the sequencer's input items and pin results.
interface clps_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;

    modport source (output valid, output action, output byte_value, input ready);
    modport sink   (input valid, input action, input byte_value, output ready);
endinterface

interface clps_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_bus;
    logic       reg_select;
    logic       read_write;
    logic       enable_line;
    logic       busy_res;
    logic       dropped;

    modport source (output valid, output data_bus, output reg_select, output read_write,
                    output enable_line, output busy_res, output dropped, input ready);
    modport sink   (input valid, input data_bus, input reg_select, input read_write,
                    input enable_line, input busy_res, input dropped, output ready);
endinterface

@@ rtl/char_lcd_parallel_sequencer_top.sv @@
// Character display sequencer: init, clear and character-write timing on tick and write items.
//
// Usage: each transaction on req is one item: action 0 is a one millisecond tick,
// action 1 writes byte_value (the clear code sends a clear command, any other byte a
// character). Every item yields exactly one transaction on rsp carrying the pin levels
// after the item, busy_res, and dropped for a write that arrived while busy.
// An accepted item's result is registered into the result register, or into the skid register if one waits.
// Throughput is one item per cycle while req.ready is high; the state update is a single registered pass.
// A two-entry output stage (result register plus skid register) parts the channels:
// a new item is taken while one result waits, and req.ready drops only when both
// entries are full because rsp stalls.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge.
// Reset: power-up wait phase, counters and pins at zero, registers at their defaults,
// output stage empty.
module char_lcd_parallel_sequencer_top
    import clps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    clps_req_if.sink   req,
    clps_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        PH_POWER,
        PH_INIT_HI,
        PH_INIT_LO,
        PH_IDLE,
        PH_CLR_HI,
        PH_CLR_LO,
        PH_CH_SETUP,
        PH_CH_HIGH,
        PH_CH_LOW
    } phase_t;

    logic [7:0] pulse_width_reg, clear_code_reg, power_wait_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] wait_reg, wait_next;
    logic [3:0] index_reg, index_next;
    logic [7:0] latched_reg, latched_next;
    logic [7:0] pdata_reg, pdata_next;
    logic       prs_reg, prs_next;
    logic       prw_reg, prw_next;
    logic       pe_reg, pe_next;
    logic       drop;

    result_t    res_next, out_reg, skid_reg;
    logic       out_valid_reg, skid_valid_reg;
    logic       in_fire, out_fire;

    logic [7:0] target;
    logic [7:0] wait_inc;
    logic       done;

    assign req.ready = ~skid_valid_reg;
    assign in_fire   = req.valid & req.ready;
    assign out_fire  = out_valid_reg & rsp.ready;

    // Target of the current waiting phase; zero behaves like one.
    always_comb
    begin
        case (phase_reg)
            PH_POWER:   target = power_wait_reg;
            PH_INIT_HI: target = pulse_width_reg;
            PH_CLR_HI:  target = pulse_width_reg;
            PH_INIT_LO: target = init_delay(index_reg);
            PH_CLR_LO:  target = CLEAR_DELAY;
            default:    target = 8'd1;
        endcase
    end

    assign wait_inc = (wait_reg == 8'hFF) ? wait_reg : wait_reg + 8'd1;
    assign done     = (wait_inc >= target);

    always_comb
    begin
        phase_next   = phase_reg;
        wait_next    = wait_reg;
        index_next   = index_reg;
        latched_next = latched_reg;
        pdata_next   = pdata_reg;
        prs_next     = prs_reg;
        prw_next     = prw_reg;
        pe_next      = pe_reg;
        drop         = 1'b0;

        if (req.action == ACT_TICK)
        begin
            if (phase_reg != PH_IDLE)
                wait_next = done ? 8'd0 : wait_inc;
            case (phase_reg)
                PH_POWER:
                begin
                    if (done)
                    begin
                        index_next = 4'd0;
                        pdata_next = init_cmd(4'd0);
                        prs_next   = 1'b0;
                        prw_next   = 1'b0;
                        pe_next    = 1'b1;
                        phase_next = PH_INIT_HI;
                    end
                end
                PH_INIT_HI, PH_CLR_HI:
                begin
                    if (done)
                    begin
                        pe_next    = 1'b0;
                        phase_next = (phase_reg == PH_INIT_HI) ? PH_INIT_LO : PH_CLR_LO;
                    end
                end
                PH_INIT_LO:
                begin
                    if (done)
                    begin
                        if ({1'b0, index_reg} + 5'd1 < 5'(INIT_STEPS))
                        begin
                            index_next = index_reg + 4'd1;
                            pdata_next = init_cmd(index_reg + 4'd1);
                            prs_next   = 1'b0;
                            prw_next   = 1'b0;
                            pe_next    = 1'b1;
                            phase_next = PH_INIT_HI;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_CLR_LO:
                begin
                    if (done)
                        phase_next = PH_IDLE;
                end
                PH_CH_SETUP:
                begin
                    if (done)
                    begin
                        pe_next    = 1'b1;
                        phase_next = PH_CH_HIGH;
                    end
                end
                PH_CH_HIGH:
                begin
                    if (done)
                    begin
                        pdata_next = latched_reg;
                        pe_next    = 1'b0;
                        phase_next = PH_CH_LOW;
                    end
                end
                PH_CH_LOW:
                begin
                    if (done)
                    begin
                        prs_next   = 1'b0;
                        prw_next   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg != PH_IDLE)
        begin
            drop = 1'b1;
        end
        else
        begin
            latched_next = req.byte_value;
            wait_next    = 8'd0;
            if (req.byte_value == clear_code_reg)
            begin
                pdata_next = CLEAR_CMD;
                prs_next   = 1'b0;
                prw_next   = 1'b0;
                pe_next    = 1'b1;
                phase_next = PH_CLR_HI;
            end
            else
            begin
                prs_next   = 1'b1;
                prw_next   = 1'b0;
                phase_next = PH_CH_SETUP;
            end
        end

        res_next.data_bus    = pdata_next;
        res_next.reg_select  = prs_next;
        res_next.read_write  = prw_next;
        res_next.enable_line = pe_next;
        res_next.busy_res    = (phase_next != PH_IDLE);
        res_next.dropped     = drop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_width_reg <= PULSE_RESET;
            clear_code_reg  <= CLEAR_RESET;
            power_wait_reg  <= POWER_RESET;
            phase_reg       <= PH_POWER;
            wait_reg        <= 8'd0;
            index_reg       <= 4'd0;
            latched_reg     <= 8'd0;
            pdata_reg       <= 8'd0;
            prs_reg         <= 1'b0;
            prw_reg         <= 1'b0;
            pe_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PULSE_WIDTH: pulse_width_reg <= cfg_data;
                    CFG_CLEAR_CODE:  clear_code_reg  <= cfg_data;
                    CFG_POWER_WAIT:  power_wait_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (in_fire)
            begin
                phase_reg   <= phase_next;
                wait_reg    <= wait_next;
                index_reg   <= index_next;
                latched_reg <= latched_next;
                pdata_reg   <= pdata_next;
                prs_reg     <= prs_next;
                prw_reg     <= prw_next;
                pe_reg      <= pe_next;
            end

            // Output stage: drain skid into the result register, else park a new result, else clear the taken result.
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_reg       <= res_next;
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_reg       <= res_next;
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.data_bus    = out_reg.data_bus;
    assign rsp.reg_select  = out_reg.reg_select;
    assign rsp.read_write  = out_reg.read_write;
    assign rsp.enable_line = out_reg.enable_line;
    assign rsp.busy_res    = out_reg.busy_res;
    assign rsp.dropped     = out_reg.dropped;

endmodule
